[design/tga_rle_pkg.sv]
// Shared types, constants and helpers for the TGA run-length pixel decoder.
// Used by tga_rle_front, tga_rle_queue, tga_rle_back and tga_rle_pixel_decoder.
`default_nettype none

package tga_rle_pkg;

    localparam int BYTE_W   = 8;
    localparam int PIXEL_W  = 32;
    localparam int COUNT_W  = 8;
    localparam int BPP_W    = 3;
    localparam int IMAGE_W  = 32;
    localparam int GATHER_W = 24;
    localparam int OUT_W    = PIXEL_W + COUNT_W;

    // Header byte layout: run flag on top, pixel count minus one below.
    localparam int RUN_FLAG_BIT = 7;
    localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h7f;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_BYTES_PER_PIXEL = 1'b0,
        REG_IMAGE_PIXELS    = 1'b1
    } reg_index_t;

    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
    localparam logic [IMAGE_W-1:0] IMAGE_RESET = 32'd65536;

    // One decoded result as it travels from the front to the output side.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               image_done;
    } result_t;

    // Pixel size in bytes minus one; zero acts as one, five to seven as four.
    function automatic logic [1:0] size_m1(input logic [BPP_W-1:0] bpp);
        logic [1:0] r;
        if (bpp == 3'd0)
            r = 2'd0;
        else if (bpp > 3'd4)
            r = 2'd3;
        else
            r = 2'(bpp - 3'd1);
        return r;
    endfunction

endpackage

`default_nettype wire

[design/tga_rle_pixel_decoder.sv]
// Top level of the TGA run-length pixel decoder.
// Instantiates tga_rle_front, tga_rle_queue and tga_rle_back; uses tga_rle_pkg.
`default_nettype none

// The decoder takes one byte of run-length coded TGA pixel data per clock
// and gives one word per decoded pixel of a raw packet, or one word per run
// packet carrying the pixel and its repeat count. Header bytes and the
// leading bytes of a pixel give no word. The result of the byte that completes
// a word is written into the two-entry queue when that byte is taken, and
// moves from there into the output register, which offers it as the word.
// The byte parser, the queue and the output register each pass one item per
// clock, so bytes flow at one per clock as long as the output is taken. A
// stalled output fills the queue and then holds off input; once a word leaves
// the full queue, input is taken again from the following clock.
// The last word of an image has tlast set, after which the next byte is read
// as the first packet header of a new image. Configuration is to be written
// by the user only while the block is idle; the block itself does not enforce
// this. bytes_per_pixel outside one to four is treated as the nearest valid size.

module tga_rle_pixel_decoder (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration write port.
    input  wire logic                                  cfg_we,
    input  wire logic [0:0]                            cfg_index,
    input  wire logic [tga_rle_pkg::IMAGE_W-1:0]       cfg_wdata,
    // Input stream.
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [tga_rle_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] stream_byte
    // Output stream.
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [tga_rle_pkg::OUT_W-1:0]              m_axis_tdata,  // [31:0] pixel_value,
                                                                      // [39:32] repeat_count
    output logic                                       m_axis_tlast   // image_done
);

    logic [tga_rle_pkg::BPP_W-1:0]   bpp_reg;
    logic [tga_rle_pkg::IMAGE_W-1:0] image_pixels_reg;

    logic                  byte_take;
    logic                  push;
    tga_rle_pkg::result_t  push_data;
    logic                  q_full;
    logic                  q_not_empty;
    logic                  q_pop;
    tga_rle_pkg::result_t  q_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg          <= tga_rle_pkg::BPP_RESET;
            image_pixels_reg <= tga_rle_pkg::IMAGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tga_rle_pkg::reg_index_t'(cfg_index))
                tga_rle_pkg::REG_BYTES_PER_PIXEL:
                    bpp_reg <= cfg_wdata[tga_rle_pkg::BPP_W-1:0];
                tga_rle_pkg::REG_IMAGE_PIXELS:
                    image_pixels_reg <= cfg_wdata;
                default:
                    bpp_reg <= bpp_reg;
            endcase
        end
    end

    // Input is taken whenever the queue has room for a possible result.
    assign s_axis_tready = !q_full;
    assign byte_take     = s_axis_tvalid && s_axis_tready;

    tga_rle_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_take),
        .byte_data       (s_axis_tdata),
        .bytes_per_pixel (bpp_reg),
        .image_pixels    (image_pixels_reg),
        .push_data       (push_data),
        .push            (push)
    );

    tga_rle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    tga_rle_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[design/tga_rle_front.sv]
// Front part of the decoder: parses packet headers, gathers pixel bytes and
// counts pixels against the image size. Depends on tga_rle_pkg.
`default_nettype none

module tga_rle_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         byte_valid,
    input  wire logic [tga_rle_pkg::BYTE_W-1:0] byte_data,
    input  wire logic [tga_rle_pkg::BPP_W-1:0]  bytes_per_pixel,
    input  wire logic [tga_rle_pkg::IMAGE_W-1:0] image_pixels,
    output tga_rle_pkg::result_t              push_data,
    output logic                              push
);

    logic                                  expect_header_reg, expect_header_next;
    logic                                  is_run_reg, is_run_next;
    logic [tga_rle_pkg::COUNT_W-1:0]       left_reg, left_next;
    logic [1:0]                            byte_pos_reg, byte_pos_next;
    logic [tga_rle_pkg::GATHER_W-1:0]      gather_reg, gather_next;
    logic [tga_rle_pkg::IMAGE_W-1:0]       emitted_reg, emitted_next;

    logic [1:0]                            pos_last;
    logic [tga_rle_pkg::IMAGE_W-1:0]       remaining;
    logic [tga_rle_pkg::COUNT_W-1:0]       count;
    logic                                  done;
    logic [tga_rle_pkg::PIXEL_W-1:0]       pixel;

    assign pos_last = tga_rle_pkg::size_m1(bytes_per_pixel);

    // Pixels left in the image; a count already at or past the size leaves one.
    assign remaining = (image_pixels > emitted_reg) ? (image_pixels - emitted_reg)
                                                    : tga_rle_pkg::IMAGE_W'(1);

    // Completed pixel: bytes gathered so far plus the current byte in its lane.
    assign pixel = {8'd0, gather_reg}
                 | (tga_rle_pkg::PIXEL_W'(byte_data) << {byte_pos_reg, 3'b000});

    // Repeat count, clipped to the image end for a run packet.
    always_comb
    begin
        if (is_run_reg)
            count = (tga_rle_pkg::IMAGE_W'(left_reg) < remaining) ? left_reg
                                                                  : remaining[7:0];
        else
            count = tga_rle_pkg::COUNT_W'(1);
        if (count == '0)
            count = tga_rle_pkg::COUNT_W'(1);
    end

    assign done = (tga_rle_pkg::IMAGE_W'(count) >= remaining);

    // Next state for each accepted byte.
    always_comb
    begin
        expect_header_next = expect_header_reg;
        is_run_next        = is_run_reg;
        left_next          = left_reg;
        byte_pos_next      = byte_pos_reg;
        gather_next        = gather_reg;
        emitted_next       = emitted_reg;
        push               = 1'b0;
        push_data.pixel_value  = pixel;
        push_data.repeat_count = count;
        push_data.image_done   = done;
        if (byte_valid)
        begin
            if (expect_header_reg)
            begin
                is_run_next        = byte_data[tga_rle_pkg::RUN_FLAG_BIT];
                left_next          = (byte_data & tga_rle_pkg::COUNT_MASK) + 8'd1;
                byte_pos_next      = 2'd0;
                gather_next        = '0;
                expect_header_next = 1'b0;
            end
            else if (byte_pos_reg < pos_last)
            begin
                gather_next[{byte_pos_reg, 3'b000} +: 8] = byte_data;
                byte_pos_next = byte_pos_reg + 2'd1;
            end
            else
            begin
                push          = 1'b1;
                gather_next   = '0;
                byte_pos_next = 2'd0;
                if (is_run_reg)
                    left_next = '0;
                else
                    left_next = (left_reg != '0) ? left_reg - 8'd1 : '0;
                if (done)
                begin
                    emitted_next       = '0;
                    is_run_next        = 1'b0;
                    left_next          = '0;
                    expect_header_next = 1'b1;
                end
                else
                begin
                    emitted_next       = emitted_reg + tga_rle_pkg::IMAGE_W'(count);
                    expect_header_next = (left_next == '0);
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            is_run_reg        <= 1'b0;
            left_reg          <= '0;
            byte_pos_reg      <= '0;
            gather_reg        <= '0;
            emitted_reg       <= '0;
        end
        else
        begin
            expect_header_reg <= expect_header_next;
            is_run_reg        <= is_run_next;
            left_reg          <= left_next;
            byte_pos_reg      <= byte_pos_next;
            gather_reg        <= gather_next;
            emitted_reg       <= emitted_next;
        end
    end

    // A finished image always returns the parser to header expectation.
    a_done_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.image_done) |=> (expect_header_reg && emitted_reg == '0))
        else $error("image end did not restart parsing");

    // A pixel byte is only taken while a packet still has pixels left.
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !expect_header_reg |-> (left_reg != '0))
        else $error("pixel byte outside a packet");

endmodule

`default_nettype wire

[design/tga_rle_queue.sv]
// Two-entry queue that decouples the byte parser from the output stage.
// Depends on tga_rle_pkg for the result record.
`default_nettype none

module tga_rle_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  tga_rle_pkg::result_t      push_data,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output tga_rle_pkg::result_t      pop_data
);

    tga_rle_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

[design/tga_rle_back.sv]
// Output stage: moves queued results into a registered stream word.
// Depends on tga_rle_pkg for the result record.
`default_nettype none

module tga_rle_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_not_empty,
    input  tga_rle_pkg::result_t                   q_data,
    output logic                                   q_pop,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [tga_rle_pkg::OUT_W-1:0]          m_axis_tdata,
    output logic                                   m_axis_tlast
);

    logic                      valid_reg;
    tga_rle_pkg::result_t      word_reg;

    // Load a new word when the register is empty or being drained.
    assign q_pop = q_not_empty && (!valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || m_axis_tready)
            valid_reg <= q_not_empty;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            word_reg <= q_data;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {word_reg.repeat_count, word_reg.pixel_value};
    assign m_axis_tlast  = word_reg.image_done;

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (word_reg.repeat_count != '0))
        else $error("result with zero repeat count");

endmodule

`default_nettype wire
